FILE: rtl/hlcp_pkg.sv
// hlcp_pkg: shared types, widths and helpers for the homogeneous line clipper.
// Used by every module of the block but hlcp_div; depends on nothing.
package hlcp_pkg;

    localparam int CW   = 32;          // clip-space coordinate width
    localparam int DW   = CW + 1;      // plane distance width
    localparam int TB   = 28;          // fraction bits of the intersection parameter
    localparam int TW   = TB + 1;      // intersection parameter width, covers 1.0
    localparam int SW   = 18;          // screen coordinate width, Q14.4
    localparam int VW   = 14;          // viewport size register width
    localparam int NPL  = 6;           // clip planes

    localparam logic [SW-1:0] SCREEN_MAX = '1;

    // register indexes of the configuration port
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [DW-1:0] dist_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        coord_t w;
    } point_t;

    typedef struct packed {
        point_t a;
        point_t b;
        dist_t  da;    // distances to the plane about to be applied
        dist_t  db;
        logic   vis;
    } seg_t;

    typedef enum logic [1:0] {
        ACT_KEEP,
        ACT_MOVE_A,
        ACT_MOVE_B,
        ACT_REJECT
    } act_t;

    function automatic coord_t get_c(input point_t p, input int unsigned k);
        coord_t c;
        unique case (k)
            0:       c = p.x;
            1:       c = p.y;
            2:       c = p.z;
            default: c = p.w;
        endcase
        return c;
    endfunction

    // signed distance to a plane; negative means outside
    function automatic dist_t plane_dist(input point_t p, input int unsigned plane);
        dist_t x;
        dist_t y;
        dist_t z;
        dist_t w;
        dist_t d;
        x = dist_t'(p.x);
        y = dist_t'(p.y);
        z = dist_t'(p.z);
        w = dist_t'(p.w);
        unique case (plane)
            0:       d = w + x;
            1:       d = w - x;
            2:       d = w + y;
            3:       d = w - y;
            4:       d = z;
            default: d = w - z;
        endcase
        return d;
    endfunction

    function automatic act_t classify(input dist_t da, input dist_t db);
        act_t act;
        priority if (da[DW-1] && db[DW-1]) act = ACT_REJECT;
        else if (da[DW-1])                act = ACT_MOVE_A;
        else if (db[DW-1])                act = ACT_MOVE_B;
        else                              act = ACT_KEEP;
        return act;
    endfunction

endpackage

FILE: rtl/hlcp_div.sv
// hlcp_div: pipelined restoring divider, one quotient bit per stage, with sideband.
// Needs num < den * 2^QW for a valid quotient. Uses no package items.
module hlcp_div #(
    parameter int NW    = 61,
    parameter int DW    = 34,
    parameter int QW    = 29,
    parameter int PW    = 8,
    parameter int LANES = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [LANES-1:0][NW-1:0]    num,
    input  logic [LANES-1:0][DW-1:0]    den,
    input  logic [PW-1:0]               side,
    output logic                        out_valid,
    output logic [LANES-1:0][QW-1:0]    quot,
    output logic [PW-1:0]               out_side
);

    logic                        valid_reg [QW];
    logic [LANES-1:0][DW-1:0]    rem_reg   [QW];
    logic [LANES-1:0][DW-1:0]    den_reg   [QW];
    logic [LANES-1:0][QW-1:0]    low_reg   [QW];
    logic [LANES-1:0][QW-1:0]    q_reg     [QW];
    logic [PW-1:0]               side_reg  [QW];

    for (genvar i = 0; i < QW; i++) begin : g_step
        logic                     v_in;
        logic [LANES-1:0][DW-1:0] rem_in;
        logic [LANES-1:0][DW-1:0] den_in;
        logic [LANES-1:0][QW-1:0] low_in;
        logic [LANES-1:0][QW-1:0] q_in;
        logic [PW-1:0]            side_in;
        logic [LANES-1:0][DW-1:0] rem_next;
        logic [LANES-1:0][QW-1:0] low_next;
        logic [LANES-1:0][QW-1:0] q_next;

        if (i == 0) begin : g_head
            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_in[l] = DW'(num[l] >> QW);
                    low_in[l] = num[l][QW-1:0];
                end
                v_in    = in_valid;
                den_in  = den;
                q_in    = '0;
                side_in = side;
            end
        end else begin : g_tail
            always_comb
            begin
                v_in    = valid_reg[i-1];
                rem_in  = rem_reg[i-1];
                den_in  = den_reg[i-1];
                low_in  = low_reg[i-1];
                q_in    = q_reg[i-1];
                side_in = side_reg[i-1];
            end
        end

        always_comb
        begin
            logic [DW:0] trial;
            logic [DW:0] dext;
            for (int l = 0; l < LANES; l++)
            begin
                trial = {rem_in[l], low_in[l][QW-1]};
                dext  = {1'b0, den_in[l]};
                if (trial >= dext)
                begin
                    rem_next[l] = DW'(trial - dext);
                    q_next[l]   = {q_in[l][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = trial[DW-1:0];
                    q_next[l]   = {q_in[l][QW-2:0], 1'b0};
                end
                low_next[l] = low_in[l] << 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                den_reg[i]  <= den_in;
                low_reg[i]  <= low_next;
                q_reg[i]    <= q_next;
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quot      = q_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

FILE: rtl/hlcp_front.sv
// hlcp_front: input transaction register; unpacks endpoints and computes their
// distances to the first clip plane. Depends on hlcp_pkg.
module hlcp_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [31:0]    start_x,
    input  logic signed [31:0]    start_y,
    input  logic signed [31:0]    start_z,
    input  logic signed [31:0]    start_w,
    input  logic signed [31:0]    end_x,
    input  logic signed [31:0]    end_y,
    input  logic signed [31:0]    end_z,
    input  logic signed [31:0]    end_w,
    input  logic                  full,
    output logic                  push,
    output hlcp_pkg::seg_t        push_seg
);

    logic           valid_reg;
    hlcp_pkg::seg_t seg_reg;
    hlcp_pkg::seg_t seg_next;

    assign in_ready = !valid_reg || !full;
    assign push     = valid_reg && !full;
    assign push_seg = seg_reg;

    always_comb
    begin
        seg_next.a   = '{x: start_x, y: start_y, z: start_z, w: start_w};
        seg_next.b   = '{x: end_x, y: end_y, z: end_z, w: end_w};
        seg_next.da  = hlcp_pkg::plane_dist(seg_next.a, 0);
        seg_next.db  = hlcp_pkg::plane_dist(seg_next.b, 0);
        seg_next.vis = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            valid_reg <= 1'b1;
        else if (push)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            seg_reg <= seg_next;
    end

endmodule

FILE: rtl/hlcp_fifo.sv
// hlcp_fifo: four-entry queue of segments with first-plane distances between front and back.
// Depends on hlcp_pkg.
module hlcp_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hlcp_pkg::seg_t push_seg,
    input  logic           pop,
    output hlcp_pkg::seg_t pop_seg,
    output logic           full,
    output logic           empty
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    hlcp_pkg::seg_t  mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW:0]     count_reg;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_seg = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_seg;
    end

endmodule

FILE: rtl/hlcp_plane.sv
// hlcp_plane: clips a segment against one plane: intersection divide, endpoint
// move, then distances for the next plane. Depends on hlcp_pkg, hlcp_div.
module hlcp_plane #(
    parameter int unsigned PLANE = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  hlcp_pkg::seg_t in_seg,
    output logic           out_valid,
    output hlcp_pkg::seg_t out_seg
);

    localparam int DW  = hlcp_pkg::DW;
    localparam int TB  = hlcp_pkg::TB;
    localparam int TW  = hlcp_pkg::TW;
    localparam int PRW = DW + TW;
    localparam int NW  = DW + TB;
    localparam int SUW = DW + 1;

    typedef struct packed {
        hlcp_pkg::seg_t        seg;
        hlcp_pkg::act_t        act;
        logic [3:0]            neg;
        logic [3:0][DW-1:0]    mag;
    } side_t;

    localparam int PW = $bits(side_t);

    // setup: magnitudes, sum and coordinate deltas
    logic [DW-1:0]           ua;
    logic [DW-1:0]           ub;
    logic [0:0][NW-1:0]      div_num;
    logic [0:0][SUW-1:0]     div_den;
    side_t                   side_next;

    always_comb
    begin
        hlcp_pkg::dist_t diff;
        ua = in_seg.da[DW-1] ? DW'(-in_seg.da) : DW'(in_seg.da);
        ub = in_seg.db[DW-1] ? DW'(-in_seg.db) : DW'(in_seg.db);
        div_num[0] = {ua, {TB{1'b0}}};
        div_den[0] = SUW'(ua) + SUW'(ub);
        side_next.seg = in_seg;
        side_next.act = hlcp_pkg::classify(in_seg.da, in_seg.db);
        for (int k = 0; k < 4; k++)
        begin
            diff = hlcp_pkg::dist_t'(hlcp_pkg::get_c(in_seg.b, k))
                 - hlcp_pkg::dist_t'(hlcp_pkg::get_c(in_seg.a, k));
            side_next.neg[k] = diff[DW-1];
            side_next.mag[k] = diff[DW-1] ? DW'(-diff) : DW'(diff);
        end
    end

    logic                 s0_valid_reg;
    logic [0:0][NW-1:0]   s0_num_reg;
    logic [0:0][SUW-1:0]  s0_den_reg;
    side_t                s0_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en)
            s0_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_num_reg  <= div_num;
            s0_den_reg  <= div_den;
            s0_side_reg <= side_next;
        end
    end

    logic              dv_valid;
    logic [0:0][TW-1:0] dv_t;
    logic [PW-1:0]     dv_side_bits;
    side_t             dv_side;

    hlcp_div #(
        .NW    (NW),
        .DW    (SUW),
        .QW    (TW),
        .PW    (PW),
        .LANES (1)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s0_valid_reg),
        .num       (s0_num_reg),
        .den       (s0_den_reg),
        .side      (s0_side_reg),
        .out_valid (dv_valid),
        .quot      (dv_t),
        .out_side  (dv_side_bits)
    );

    assign dv_side = side_t'(dv_side_bits);

    // multiply stage: |delta| * t per coordinate
    logic                  m_valid_reg;
    logic [3:0][PRW-1:0]   m_prod_reg;
    side_t                 m_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
                m_prod_reg[k] <= PRW'(dv_side.mag[k]) * PRW'(dv_t[0]);
            m_side_reg <= dv_side;
        end
    end

    // round half away from zero, then move the outside endpoint or mark a reject
    hlcp_pkg::seg_t r_seg_next;

    always_comb
    begin
        logic [PRW-1:0]        rnd;
        logic [DW-1:0]         r;
        hlcp_pkg::dist_t       av;
        hlcp_pkg::dist_t       sum;
        hlcp_pkg::coord_t      res [4];
        hlcp_pkg::point_t      mp;
        for (int k = 0; k < 4; k++)
        begin
            rnd = m_prod_reg[k] + (PRW'(1) << (TB - 1));
            r   = rnd[TB +: DW];
            av  = hlcp_pkg::dist_t'(hlcp_pkg::get_c(m_side_reg.seg.a, k));
            sum = m_side_reg.neg[k] ? av - hlcp_pkg::dist_t'(r) : av + hlcp_pkg::dist_t'(r);
            res[k] = sum[hlcp_pkg::CW-1:0];
        end
        mp = '{x: res[0], y: res[1], z: res[2], w: res[3]};
        r_seg_next = m_side_reg.seg;
        unique case (m_side_reg.act)
            hlcp_pkg::ACT_MOVE_A: r_seg_next.a   = mp;
            hlcp_pkg::ACT_MOVE_B: r_seg_next.b   = mp;
            hlcp_pkg::ACT_REJECT: r_seg_next.vis = 1'b0;
            hlcp_pkg::ACT_KEEP:   r_seg_next     = m_side_reg.seg;
        endcase
    end

    logic           r_valid_reg;
    hlcp_pkg::seg_t r_seg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r_valid_reg <= 1'b0;
        else if (en)
            r_valid_reg <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            r_seg_reg <= r_seg_next;
    end

    // distances against the following plane
    logic           d_valid_reg;
    hlcp_pkg::seg_t d_seg_reg;
    hlcp_pkg::seg_t d_seg_next;

    always_comb
    begin
        d_seg_next    = r_seg_reg;
        d_seg_next.da = hlcp_pkg::plane_dist(r_seg_reg.a, PLANE + 1);
        d_seg_next.db = hlcp_pkg::plane_dist(r_seg_reg.b, PLANE + 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (en)
            d_valid_reg <= r_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_seg_reg <= d_seg_next;
    end

    assign out_valid = d_valid_reg;
    assign out_seg   = d_seg_reg;

endmodule

FILE: rtl/hlcp_project.sv
// hlcp_project: w test, perspective divide and viewport mapping to Q14.4,
// four lanes through one shared divider pipeline. Depends on hlcp_pkg, hlcp_div.
module hlcp_project #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  hlcp_pkg::seg_t               in_seg,
    input  logic [hlcp_pkg::VW-1:0]      vp_width,
    input  logic [hlcp_pkg::VW-1:0]      vp_height,
    output logic                         out_valid,
    output logic                         out_vis,
    output logic [3:0][hlcp_pkg::SW-1:0] out_screen
);

    localparam int CW   = hlcp_pkg::CW;
    localparam int VW   = hlcp_pkg::VW;
    localparam int SW   = hlcp_pkg::SW;
    localparam int PRW  = CW + VW;
    localparam int NW   = PRW + 5;
    localparam int HW   = NW - SW;
    localparam int WMIN_I = (1 << FRAC_BITS) / 1000000;
    localparam hlcp_pkg::coord_t WMIN = hlcp_pkg::coord_t'(WMIN_I);

    typedef struct packed {
        logic [3:0] pos;
        logic [3:0] ovf;
        logic       vis;
    } side_t;

    localparam int PW = $bits(side_t);

    // stage 0: w test and c + w per lane (x0, y0, x1, y1)
    logic                 vis_next;
    logic [3:0]           pos_next;
    logic [3:0][CW-1:0]   num_next;
    logic [3:0][CW-1:0]   w_next;
    logic [3:0][VW-1:0]   size_next;

    always_comb
    begin
        hlcp_pkg::coord_t c [4];
        hlcp_pkg::coord_t w [4];
        hlcp_pkg::dist_t  s;
        c[0] = in_seg.a.x; w[0] = in_seg.a.w; size_next[0] = vp_width;
        c[1] = in_seg.a.y; w[1] = in_seg.a.w; size_next[1] = vp_height;
        c[2] = in_seg.b.x; w[2] = in_seg.b.w; size_next[2] = vp_width;
        c[3] = in_seg.b.y; w[3] = in_seg.b.w; size_next[3] = vp_height;
        vis_next = in_seg.vis && (in_seg.a.w > WMIN) && (in_seg.b.w > WMIN);
        for (int k = 0; k < 4; k++)
        begin
            s = hlcp_pkg::dist_t'(c[k]) + hlcp_pkg::dist_t'(w[k]);
            pos_next[k] = !s[CW] && (s != '0);
            num_next[k] = s[CW-1:0];
            w_next[k]   = w[k];
        end
    end

    logic                 p0_valid_reg;
    logic                 p0_vis_reg;
    logic [3:0]           p0_pos_reg;
    logic [3:0][CW-1:0]   p0_num_reg;
    logic [3:0][CW-1:0]   p0_w_reg;
    logic [3:0][VW-1:0]   p0_size_reg;

    // stage 1: scale by viewport size
    logic                 p1_valid_reg;
    logic                 p1_vis_reg;
    logic [3:0]           p1_pos_reg;
    logic [3:0][PRW-1:0]  p1_prod_reg;
    logic [3:0][CW-1:0]   p1_w_reg;

    // stage 2: numerator 16*c'*size + w, denominator 2w
    logic                 p2_valid_reg;
    logic                 p2_vis_reg;
    logic [3:0]           p2_pos_reg;
    logic [3:0][NW-1:0]   p2_n_reg;
    logic [3:0][CW-1:0]   p2_d_reg;

    // stage 3: saturation check, quotient would not fit 18 bits
    logic                 p3_valid_reg;
    logic [3:0][NW-1:0]   p3_n_reg;
    logic [3:0][CW-1:0]   p3_d_reg;
    side_t                p3_side_reg;
    side_t                p3_side_next;
    logic [3:0][NW-1:0]   p3_n_next;

    always_comb
    begin
        p3_side_next.vis = p2_vis_reg;
        p3_side_next.pos = p2_pos_reg;
        for (int k = 0; k < 4; k++)
        begin
            p3_side_next.ovf[k] = p2_n_reg[k][NW-1:SW] >= HW'(p2_d_reg[k]);
            p3_n_next[k] = p3_side_next.ovf[k] ? '0 : p2_n_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p0_valid_reg <= in_valid;
            p1_valid_reg <= p0_valid_reg;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_vis_reg  <= vis_next;
            p0_pos_reg  <= pos_next;
            p0_num_reg  <= num_next;
            p0_w_reg    <= w_next;
            p0_size_reg <= size_next;

            p1_vis_reg <= p0_vis_reg;
            p1_pos_reg <= p0_pos_reg;
            p1_w_reg   <= p0_w_reg;
            for (int k = 0; k < 4; k++)
                p1_prod_reg[k] <= PRW'(p0_num_reg[k]) * PRW'(p0_size_reg[k]);

            p2_vis_reg <= p1_vis_reg;
            p2_pos_reg <= p1_pos_reg;
            for (int k = 0; k < 4; k++)
            begin
                p2_n_reg[k] <= {1'b0, p1_prod_reg[k], 4'b0000} + NW'(p1_w_reg[k]);
                p2_d_reg[k] <= {p1_w_reg[k][CW-2:0], 1'b0};
            end

            p3_n_reg    <= p3_n_next;
            p3_d_reg    <= p2_d_reg;
            p3_side_reg <= p3_side_next;
        end
    end

    logic                 dv_valid;
    logic [3:0][SW-1:0]   dv_q;
    logic [PW-1:0]        dv_side_bits;
    side_t                dv_side;

    hlcp_div #(
        .NW    (NW),
        .DW    (CW),
        .QW    (SW),
        .PW    (PW),
        .LANES (4)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p3_valid_reg),
        .num       (p3_n_reg),
        .den       (p3_d_reg),
        .side      (p3_side_reg),
        .out_valid (dv_valid),
        .quot      (dv_q),
        .out_side  (dv_side_bits)
    );

    assign dv_side   = side_t'(dv_side_bits);
    assign out_valid = dv_valid;
    assign out_vis   = dv_side.vis;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            priority if (!dv_side.vis || !dv_side.pos[k])
                out_screen[k] = '0;
            else if (dv_side.ovf[k])
                out_screen[k] = hlcp_pkg::SCREEN_MAX;
            else
                out_screen[k] = dv_q[k];
        end
    end

endmodule

FILE: rtl/homogeneous_line_clip_project_top.sv
// homogeneous_line_clip_project_top: line clipper top level: config registers,
// front end, queue, six plane stages, projector and output register.
// Depends on hlcp_pkg, hlcp_front, hlcp_fifo, hlcp_plane, hlcp_project.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one segment per transaction:
//   two clip-space endpoints, signed Q16.16. Output channel
//   (out_valid/out_ready) returns exactly one transaction per segment:
//   visible plus two viewport points in unsigned Q14.4, all zero when the
//   segment is rejected or an endpoint has w too close to zero.
//   Throughput: one segment per cycle when the receiver keeps out_ready high.
//   The path to out_valid runs through the seven bit-serial divider
//   pipelines (six 29-stage intersection divides, one 18-stage perspective
//   divide) plus 4 stages per plane, 4 projector stages, front register,
//   queue and output register.
//   Back end moves as one pipeline; when out_valid is high and out_ready is
//   low the whole back end holds. The front register and a 4-entry queue
//   keep taking transactions until the queue fills.
//   cfg_we writes viewport_width (index 0) or viewport_height (index 1);
//   write only while no transaction is in flight.
//   Reset (rst_n low, asynchronous) empties every stage and the queue and
//   sets the viewport to 1024 x 768.
module homogeneous_line_clip_project_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [13:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  start_x,
    input  logic signed [31:0]  start_y,
    input  logic signed [31:0]  start_z,
    input  logic signed [31:0]  start_w,
    input  logic signed [31:0]  end_x,
    input  logic signed [31:0]  end_y,
    input  logic signed [31:0]  end_z,
    input  logic signed [31:0]  end_w,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                visible,
    output logic [17:0]         screen_x0,
    output logic [17:0]         screen_y0,
    output logic [17:0]         screen_x1,
    output logic [17:0]         screen_y1
);

    localparam int NPL = hlcp_pkg::NPL;
    localparam int SW  = hlcp_pkg::SW;

    // viewport configuration
    logic [hlcp_pkg::VW-1:0] vp_width_reg;
    logic [hlcp_pkg::VW-1:0] vp_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_width_reg  <= 14'd1024;
            vp_height_reg <= 14'd768;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hlcp_pkg::REG_WIDTH:  vp_width_reg  <= cfg_data;
                hlcp_pkg::REG_HEIGHT: vp_height_reg <= cfg_data;
            endcase
        end
    end

    // back end advances whenever the output register is free or being taken
    logic adv;
    logic out_valid_reg;

    assign adv = !out_valid_reg || out_ready;

    // front end and queue
    logic           q_push;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    hlcp_pkg::seg_t q_push_seg;
    hlcp_pkg::seg_t q_pop_seg;

    hlcp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .start_x  (start_x),
        .start_y  (start_y),
        .start_z  (start_z),
        .start_w  (start_w),
        .end_x    (end_x),
        .end_y    (end_y),
        .end_z    (end_z),
        .end_w    (end_w),
        .full     (q_full),
        .push     (q_push),
        .push_seg (q_push_seg)
    );

    assign q_pop = adv && !q_empty;

    hlcp_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_seg (q_push_seg),
        .pop      (q_pop),
        .pop_seg  (q_pop_seg),
        .full     (q_full),
        .empty    (q_empty)
    );

    // six clip planes in order w+x, w-x, w+y, w-y, z, w-z
    logic           pl_valid [NPL+1];
    hlcp_pkg::seg_t pl_seg   [NPL+1];

    assign pl_valid[0] = !q_empty;
    assign pl_seg[0]   = q_pop_seg;

    for (genvar p = 0; p < NPL; p++) begin : g_plane
        hlcp_plane #(
            .PLANE (p)
        ) u_plane (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (pl_valid[p]),
            .in_seg    (pl_seg[p]),
            .out_valid (pl_valid[p+1]),
            .out_seg   (pl_seg[p+1])
        );
    end

    // projection to viewport
    logic                prj_valid;
    logic                prj_vis;
    logic [3:0][SW-1:0]  prj_screen;

    hlcp_project #(
        .FRAC_BITS (FRAC_BITS)
    ) u_project (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_valid   (pl_valid[NPL]),
        .in_seg     (pl_seg[NPL]),
        .vp_width   (vp_width_reg),
        .vp_height  (vp_height_reg),
        .out_valid  (prj_valid),
        .out_vis    (prj_vis),
        .out_screen (prj_screen)
    );

    // output register
    logic                visible_reg;
    logic [3:0][SW-1:0]  screen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= prj_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && prj_valid)
        begin
            visible_reg <= prj_vis;
            screen_reg  <= prj_screen;
        end
    end

    assign out_valid = out_valid_reg;
    assign visible   = visible_reg;
    assign screen_x0 = screen_reg[0];
    assign screen_y0 = screen_reg[1];
    assign screen_x1 = screen_reg[2];
    assign screen_y1 = screen_reg[3];

endmodule

FILE: test/tb_homogeneous_line_clip_project_top.sv
`timescale 1ns / 1ps
// tb_homogeneous_line_clip_project_top: self-checking bench for the line clipper.
// Directed table plus random segments, each result checked against a typed-in result or a local model.
// Depends on hlcp_pkg and homogeneous_line_clip_project_top.
module tb_homogeneous_line_clip_project_top;

    localparam int FRAC      = 16;
    localparam int T_FRAC    = 28;
    localparam int N_RANDOM  = 1100;
    localparam int DRAIN_CYC = 400;   // extra settling time after every expected line is out
    localparam int WDOG_MAX  = 5000;  // idle cycles allowed with nothing accepted

    typedef struct {
        logic signed [31:0] c[8];    // start x,y,z,w then end x,y,z,w
    } seg_in_t;

    typedef struct {
        logic        vis;
        logic [17:0] x0;
        logic [17:0] y0;
        logic [17:0] x1;
        logic [17:0] y1;
    } line_out_t;

    // directed row: the segment, plus an optional typed-in result
    typedef struct {
        seg_in_t   seg;
        logic      known;
        line_out_t res;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_index;
    logic [13:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] start_x, start_y, start_z, start_w;
    logic signed [31:0] end_x, end_y, end_z, end_w;
    logic               out_valid;
    logic               out_ready;
    logic               visible;
    logic [17:0]        screen_x0, screen_y0, screen_x1, screen_y1;

    // local copy of the viewport registers
    logic [13:0] vp_w;
    logic [13:0] vp_h;

    line_out_t expected_lines[$];
    int        mismatches = 0;
    int        idle_cycles = 0;
    bit        stim_done;

    homogeneous_line_clip_project_top #(.FRAC_BITS(FRAC)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .start_x(start_x), .start_y(start_y), .start_z(start_z), .start_w(start_w),
        .end_x(end_x), .end_y(end_y), .end_z(end_z), .end_w(end_w),
        .out_valid(out_valid), .out_ready(out_ready),
        .visible(visible),
        .screen_x0(screen_x0), .screen_y0(screen_y0),
        .screen_x1(screen_x1), .screen_y1(screen_y1)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic longint plane_distance(input longint p[4], input int plane);
        longint d;
        case (plane)
            0:       d = p[3] + p[0];
            1:       d = p[3] - p[0];
            2:       d = p[3] + p[1];
            3:       d = p[3] - p[1];
            4:       d = p[2];
            default: d = p[3] - p[2];
        endcase
        return d;
    endfunction

    // (c + w) * size * 8 / w, rounded half up, saturated to 18 bits
    function automatic logic [17:0] viewport_coord(input longint c, input longint w,
                                                   input logic [13:0] size);
        longint      num;
        logic [63:0] q;
        num = c + w;
        if (num <= 0)
            return '0;
        q = (64'(num) * 64'(size) * 64'd16 + 64'(w)) / (64'd2 * 64'(w));
        return (q > 64'd262143) ? 18'h3FFFF : q[17:0];
    endfunction

    function automatic line_out_t clip_and_project(input seg_in_t s);
        longint      a[4];
        longint      b[4];
        longint      m[4];
        longint      da, db, diff, lim;
        logic [63:0] ua, ub, t, prod, r;
        logic        vis;
        line_out_t   res;
        vis = 1'b1;
        for (int k = 0; k < 4; k++)
        begin
            a[k] = s.c[k];
            b[k] = s.c[4 + k];
        end
        for (int plane = 0; plane < hlcp_pkg::NPL; plane++)
        begin
            da = plane_distance(a, plane);
            db = plane_distance(b, plane);
            if (da < 0 && db < 0)
            begin
                vis = 1'b0;
                break;
            end
            if ((da < 0) != (db < 0))
            begin
                ua = (da < 0) ? -da : da;
                ub = (db < 0) ? -db : db;
                t  = (ua << T_FRAC) / (ua + ub);
                for (int k = 0; k < 4; k++)
                begin
                    diff = b[k] - a[k];
                    prod = 64'((diff < 0) ? -diff : diff) * t;
                    r    = (prod + (64'd1 << (T_FRAC - 1))) >> T_FRAC;
                    m[k] = (diff < 0) ? a[k] - longint'(r) : a[k] + longint'(r);
                end
                if (da < 0)
                    a = m;
                else
                    b = m;
            end
        end
        lim = longint'(1) << FRAC;
        if (vis && !(a[3] * 1000000 > lim && b[3] * 1000000 > lim))
            vis = 1'b0;
        res = '{1'b0, '0, '0, '0, '0};
        if (vis)
        begin
            res.vis = 1'b1;
            res.x0  = viewport_coord(a[0], a[3], vp_w);
            res.y0  = viewport_coord(a[1], a[3], vp_h);
            res.x1  = viewport_coord(b[0], b[3], vp_w);
            res.y1  = viewport_coord(b[1], b[3], vp_h);
        end
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------
    task automatic send_segment(input seg_in_t s, input logic has_res, input line_out_t res);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0)
            gap = 0;   // stretches of back-to-back transactions
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        start_x <= s.c[0]; start_y <= s.c[1]; start_z <= s.c[2]; start_w <= s.c[3];
        end_x   <= s.c[4]; end_y   <= s.c[5]; end_z   <= s.c[6]; end_w   <= s.c[7];
        // prediction queued once the transaction is taken
        do @(posedge clk); while (!in_ready);
        expected_lines.push_back(has_res ? res : clip_and_project(s));
    endtask

    task automatic write_reg(input logic idx, input logic [13:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == hlcp_pkg::REG_WIDTH)
            vp_w = val;
        else
            vp_h = val;
        @(posedge clk);
    endtask

    // wait for every outstanding line, then let the pipeline settle
    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (expected_lines.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    function automatic seg_in_t make_seg(input int sx, sy, sz, sw, ex, ey, ez, ew);
        seg_in_t s;
        s.c = '{sx, sy, sz, sw, ex, ey, ez, ew};
        return s;
    endfunction

    // random segment, mostly near the view volume so clipping is exercised
    function automatic seg_in_t rand_seg();
        seg_in_t s;
        int      w;
        int      mode;
        mode = $urandom_range(0, 9);
        for (int e = 0; e < 2; e++)
        begin
            if (mode == 0)
            begin
                for (int k = 0; k < 4; k++)
                    s.c[4 * e + k] = $urandom();
            end
            else
            begin
                w = $urandom_range(1, (mode < 5) ? 32'h0004_0000 : 32'h7FFF_0000);
                if ($urandom_range(0, 9) == 0)
                    w = -w;
                for (int k = 0; k < 3; k++)
                    s.c[4 * e + k] = (mode > 7) ? int'($urandom()) :
                        ((w < 0 ? -w : w) / 2) - int'($urandom_range(0, 32'h7FFF_FFFF))
                        % ((w < 0 ? -w : w) + 1) * 2 / 2;
                s.c[4 * e + 3] = w;
            end
        end
        return s;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    localparam int ONE = 32'h0001_0000;
    localparam int MAXI = 32'h7FFF_FFFF;
    localparam int MINI = 32'h8000_0000;

    initial
    begin
        dir_row_t  dir_rows[$];
        line_out_t zero_line;
        line_out_t centre_line;
        logic [13:0] sizes[4];
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = hlcp_pkg::REG_WIDTH;
        cfg_data  = '0;
        in_valid  = 1'b0;
        {start_x, start_y, start_z, start_w} = '0;
        {end_x, end_y, end_z, end_w} = '0;
        vp_w      = 14'd1024;
        vp_h      = 14'd768;
        stim_done = 1'b0;
        zero_line   = '{1'b0, '0, '0, '0, '0};
        centre_line = '{1'b1, 18'd8192, 18'd6144, 18'd8192, 18'd6144};

        // directed table: visible in centre, rejections, w tests, extremes
        dir_rows = '{
            '{make_seg(0, 0, 0, ONE, 0, 0, 0, ONE), 1'b1, centre_line},
            '{make_seg(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, zero_line},
            '{make_seg(-2*ONE, 0, 0, ONE, -3*ONE, 0, 0, ONE), 1'b1, zero_line},
            '{make_seg(2*ONE, 0, 0, ONE, 3*ONE, 0, 0, ONE), 1'b1, zero_line},
            '{make_seg(0, -2*ONE, 0, ONE, 0, -3*ONE, 0, ONE), 1'b1, zero_line},
            '{make_seg(0, 2*ONE, 0, ONE, 0, 3*ONE, 0, ONE), 1'b1, zero_line},
            '{make_seg(0, 0, -ONE, ONE, 0, 0, -5, ONE), 1'b1, zero_line},
            '{make_seg(0, 0, 2*ONE, ONE, 0, 0, 3*ONE, ONE), 1'b1, zero_line},
            '{make_seg(0, 0, 0, -ONE, 0, 0, 0, -ONE), 1'b1, zero_line},
            '{make_seg(0, 0, 0, 0, 0, 0, 0, ONE), 1'b0, zero_line},
            '{make_seg(-2*ONE, 0, ONE/2, ONE, 2*ONE, 0, ONE/2, ONE), 1'b0, zero_line},
            '{make_seg(0, -2*ONE, ONE/2, ONE, 0, 2*ONE, ONE/2, ONE), 1'b0, zero_line},
            '{make_seg(0, 0, -ONE, ONE, 0, 0, 2*ONE, ONE), 1'b0, zero_line},
            '{make_seg(MAXI, MAXI, MAXI, MAXI, MINI, MINI, MINI, MINI), 1'b0, zero_line},
            '{make_seg(MINI, MINI, MINI, MAXI, MAXI, MAXI, MAXI, MAXI), 1'b0, zero_line},
            '{make_seg(-MAXI, MAXI, 0, MAXI, MAXI, -MAXI, MAXI, MAXI), 1'b0, zero_line},
            '{make_seg(-1, -1, -1, -1, -1, -1, -1, -1), 1'b1, zero_line},
            '{make_seg(0, 0, 0, 1, 0, 0, 0, 1), 1'b1, centre_line},
            '{make_seg(0, 0, 0, 2, 0, 0, 0, 2), 1'b0, zero_line},
            '{make_seg(-5, -5, 0, 5, 5, 5, 5, 5), 1'b0, zero_line}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_segment(dir_rows[i].seg, dir_rows[i].known, dir_rows[i].res);
        drain_pipe();

        // random phases across viewport settings, extremes included
        sizes = '{14'd1, 14'd8192, 14'd16383, 14'd0};
        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(hlcp_pkg::REG_WIDTH, (phase < 4) ? sizes[phase] : 14'($urandom()));
            write_reg(hlcp_pkg::REG_HEIGHT, (phase < 4) ? sizes[3 - phase] : 14'($urandom()));
            for (int n = 0; n < N_RANDOM / 6; n++)
                send_segment(rand_seg(), 1'b0, zero_line);
            drain_pipe();
        end
        stim_done = 1'b1;
    end

    // ---------------------------------------------------------------
    // Output side: random stalls, in-order checking
    // ---------------------------------------------------------------
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        line_out_t exp_line;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_lines.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output transaction at %0t", $time);
            end
            else
            begin
                exp_line = expected_lines.pop_front();
                if (visible !== exp_line.vis || screen_x0 !== exp_line.x0
                    || screen_y0 !== exp_line.y0 || screen_x1 !== exp_line.x1
                    || screen_y1 !== exp_line.y1)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t: exp vis=%0d p0=(%0d,%0d) p1=(%0d,%0d) got vis=%0d p0=(%0d,%0d) p1=(%0d,%0d)",
                                 $time, exp_line.vis, exp_line.x0, exp_line.y0,
                                 exp_line.x1, exp_line.y1, visible, screen_x0,
                                 screen_y0, screen_x1, screen_y1);
                end
            end
        end
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        fork
            begin
                wait (stim_done);
                if (mismatches == 0 && expected_lines.size() == 0)
                    $display("homogeneous_line_clip_project_top verification clean");
                else
                    $display("homogeneous_line_clip_project_top verification failed");
            end
            begin
                wait (idle_cycles >= WDOG_MAX);
                $display("homogeneous_line_clip_project_top verification failed");
            end
        join_any
        $finish;
    end
endmodule

FILE: sim.f
rtl/hlcp_pkg.sv
rtl/hlcp_div.sv
rtl/hlcp_front.sv
rtl/hlcp_fifo.sv
rtl/hlcp_plane.sv
rtl/hlcp_project.sv
rtl/homogeneous_line_clip_project_top.sv
test/tb_homogeneous_line_clip_project_top.sv
